@@ src/b64x_pkg.sv @@
// Package for the base64 decoder with XOR key: constants, codes and the
// alphabet lookup. No dependencies.
package b64x_pkg;

  localparam int MAX_KEY_BYTES = 8;
  localparam int COUNT_BITS    = 16;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [6:0] B64_NONE = 7'd64;

  // Configuration register indexes
  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  // End status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ILLEGAL_PAD = 2'd1;
  localparam logic [1:0] ST_PREMATURE   = 2'd2;
  localparam logic [1:0] ST_PAD_MISSING = 2'd3;

  // Map a character to its 6-bit value; B64_NONE for anything outside the alphabet
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] v;
    v = B64_NONE;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) v = 7'd62;
    else if (c == 8'h2F) v = 7'd63;
    return v;
  endfunction

endpackage

@@ src/base64_decoder_xor_key.sv @@
// Base64 decoder with cyclic XOR key on the decoded bytes.
// Depends on b64x_pkg for codes, constants and the alphabet lookup.
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+------------------------------
//   in      | in_valid, in_ready, in_char            | one character per item
//   out     | out_valid, out_ready, out_byte, ...    | decoded byte or end-of-string
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata        | key bytes / key length write
//
// One item per cycle while out_ready is high: each character is decoded in the cycle
// it is accepted and its result, if any, lands in the output register on the same
// edge, so out_valid is high in the cycle after the character is taken.
// in_ready is high while the output register is empty or drains this cycle; while
// a result waits unread, every character stalls, also one that would yield none.
// Reset (rst_n low, synchronous) clears the decoder state, the output register
// and both configuration registers.
module base64_decoder_xor_key
  import b64x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_end,
  output logic [1:0]  out_status,
  output logic [15:0] out_byte_count,

  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Quadruplet position, plus a wait for the second pad character
  typedef enum logic [2:0] {
    PH_Q0, PH_Q1, PH_Q2, PH_Q3, PH_PADWAIT
  } phase_t;

  // Configuration
  logic [63:0] key_bytes_r;
  logic [3:0]  key_length_r;

  // Per-string state
  phase_t                phase_r, phase_nxt;
  logic [23:0]           accum_r, accum_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [2:0]            key_idx_r, key_idx_nxt;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_bv_r, out_bv_nxt;
  logic        out_fe_r, out_fe_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic [15:0] out_cnt_r, out_cnt_nxt;
  logic        res_load;

  logic        in_fire;
  logic [6:0]  char_val;
  logic [5:0]  v6;
  logic        emit;
  logic [7:0]  raw_byte;
  logic [3:0]  key_len;
  logic [3:0]  idx_ext;
  logic [2:0]  idx_use;
  logic [3:0]  idx_inc;
  logic [7:0]  key_byte;
  logic [15:0] count_sat;
  logic [1:0]  end_status;

  // Accept whenever the output slot is free or drains this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign char_val = b64_value(in_char);
  assign v6       = char_val[5:0];

  // Key length above the key store acts as the full store
  assign key_len = (key_length_r > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length_r;

  // Index past the key length (length changed mid-string) falls back to byte 0
  assign idx_ext  = {1'b0, key_idx_r};
  assign idx_use  = (idx_ext >= key_len) ? 3'd0 : key_idx_r;
  assign idx_inc  = {1'b0, idx_use} + 4'd1;
  assign key_byte = key_bytes_r[idx_use*8 +: 8];

  // Report the count saturated to the 16-bit field
  assign count_sat = ((count_r >> 16) != '0) ? 16'hFFFF : 16'(count_r);

  assign end_status = (err_r == ST_OK && phase_r != PH_Q0) ? ST_PREMATURE : err_r;

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    err_nxt     = err_r;
    count_nxt   = count_r;
    key_idx_nxt = key_idx_r;
    emit        = 1'b0;
    raw_byte    = 8'h00;
    res_load    = 1'b0;
    out_byte_nxt = 8'h00;
    out_bv_nxt   = 1'b0;
    out_fe_nxt   = 1'b0;
    out_st_nxt   = ST_OK;
    out_cnt_nxt  = 16'h0000;

    if (in_fire) begin
      if (in_char == 8'h00) begin
        // End of string: report status and count, then clear the string state
        res_load    = 1'b1;
        out_fe_nxt  = 1'b1;
        out_st_nxt  = end_status;
        out_cnt_nxt = count_sat;
        phase_nxt   = PH_Q0;
        accum_nxt   = '0;
        err_nxt     = ST_OK;
        count_nxt   = '0;
        key_idx_nxt = '0;
      end else if (err_r != ST_OK || in_char[7] ||
                   (char_val == B64_NONE && in_char != PAD_CHAR)) begin
        // Drop: after an error, high-bit bytes, characters outside the alphabet other than the pad
      end else begin
        case (phase_r)
          PH_Q0: begin
            if (in_char == PAD_CHAR) begin
              err_nxt = ST_ILLEGAL_PAD;
            end else begin
              accum_nxt = {v6, 18'h0};
              phase_nxt = PH_Q1;
            end
          end
          PH_Q1: begin
            if (in_char == PAD_CHAR) begin
              err_nxt = ST_ILLEGAL_PAD;
            end else begin
              accum_nxt = accum_r | {6'h0, v6, 12'h0};
              phase_nxt = PH_Q2;
              emit      = 1'b1;
              raw_byte  = accum_nxt[23:16];
            end
          end
          PH_Q2: begin
            if (in_char == PAD_CHAR) begin
              phase_nxt = PH_PADWAIT;
            end else begin
              accum_nxt = accum_r | {12'h0, v6, 6'h0};
              phase_nxt = PH_Q3;
              emit      = 1'b1;
              raw_byte  = accum_nxt[15:8];
            end
          end
          PH_Q3: begin
            phase_nxt = PH_Q0;
            if (in_char != PAD_CHAR) begin
              accum_nxt = accum_r | {18'h0, v6};
              emit      = 1'b1;
              raw_byte  = accum_nxt[7:0];
            end
          end
          PH_PADWAIT: begin
            if (in_char != PAD_CHAR) err_nxt = ST_PAD_MISSING;
            else phase_nxt = PH_Q0;
          end
          default: begin
            phase_nxt = PH_Q0;
          end
        endcase

        if (emit) begin
          res_load     = 1'b1;
          out_bv_nxt   = 1'b1;
          out_byte_nxt = raw_byte;
          if (key_len != 4'd0) begin
            out_byte_nxt = raw_byte ^ key_byte;
            key_idx_nxt  = (idx_inc >= key_len) ? 3'd0 : idx_inc[2:0];
          end
          if (count_r != '1) count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= '0;
      key_length_r <= '0;
      phase_r      <= PH_Q0;
      accum_r      <= '0;
      err_r        <= ST_OK;
      count_r      <= '0;
      key_idx_r    <= '0;
      out_valid_r  <= 1'b0;
      out_byte_r   <= '0;
      out_bv_r     <= 1'b0;
      out_fe_r     <= 1'b0;
      out_st_r     <= ST_OK;
      out_cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KEY_BYTES:  key_bytes_r  <= cfg_wdata;
          REG_KEY_LENGTH: key_length_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      phase_r   <= phase_nxt;
      accum_r   <= accum_nxt;
      err_r     <= err_nxt;
      count_r   <= count_nxt;
      key_idx_r <= key_idx_nxt;
      // Hold the result until taken; load a new one when produced
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (res_load) begin
        out_byte_r <= out_byte_nxt;
        out_bv_r   <= out_bv_nxt;
        out_fe_r   <= out_fe_nxt;
        out_st_r   <= out_st_nxt;
        out_cnt_r  <= out_cnt_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_frame_end  = out_fe_r;
  assign out_status     = out_st_r;
  assign out_byte_count = out_cnt_r;

endmodule
